// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file stf_checker.sv.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define STF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define STF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== src/stf_pkg.sv =====
// Types and constants of the sorted tag filter.
// No dependencies; used by every module of the block.
package stf_pkg;

   localparam int TAG_W = 32;
   localparam logic [15:0] ITEM_GROUP = 16'hFFFE;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ADD_INSERTED  = 2'd0,
      ADD_DUPLICATE = 2'd1,
      ADD_FULL      = 2'd2
   } add_status_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [TAG_W-1:0] tag;
   } req_type;

   typedef struct packed {
      logic       read_element;
      logic       stop_reading;
      logic [1:0] add_status;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_COMPARE,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [TAG_W-1:0] tag;
   } cell_ctrl_type;

endpackage

// ===== src/sorted_tag_filter_unit.sv =====
// Sorted tag filter: a row of tag cells plus the command sequencer.
// Depends on stf_pkg and stf_cell.
//
// Use: drive req_data and raise start; the transaction is accepted at a rising
// edge where start is high and busy is low. Commands are add (insert a tag in
// ascending order), clear (empty the set) and query (read / skip / stop for an
// incoming element tag; a read tag is removed from the set).
// Every accepted transaction gives one result on rsp_data, valid for exactly one
// cycle with rsp_strobe high. The receiver cannot stall; it must take it then.
// The sequencer steps through compare (every cell compares its slot against the
// tag), decide (the cell flags are reduced) and apply (the row shifts), then
// registers the result. busy stays high while the sequencer is in these states,
// so a new transaction is accepted only once the last one is done.
// Reset (synchronous, active high) empties the set and idles the sequencer;
// the slot contents themselves are not cleared, only the fill count.
module sorted_tag_filter_unit #(
   parameter int TAG_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  stf_pkg::req_type req_data,
   output logic             rsp_strobe,
   output stf_pkg::rsp_type rsp_data
);
   import stf_pkg::*;

   localparam int CW = $clog2(TAG_SLOTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_DECIDE,
      ST_APPLY
   } state_type;

   state_type        state_ff;
   req_type          req_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             any_eq_ff;
   logic             all_lt_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             rsp_strobe_ff;
   cell_ctrl_type    cell_ctrl;
   cell_op_type      apply_op;

   logic [TAG_W-1:0]     tag_vec [TAG_SLOTS];
   logic [TAG_SLOTS-1:0] lt_vec;
   logic [TAG_SLOTS-1:0] eq_vec;
   logic [TAG_SLOTS-1:0] occ_vec;

   genvar gi;
   generate
      for (gi = 0; gi < TAG_SLOTS; gi++) begin : g_cell
         logic             left_lt;
         logic [TAG_W-1:0] left_tag;
         logic [TAG_W-1:0] right_tag;

         assign occ_vec[gi] = CW'(gi) < count_ff;

         if (gi == 0) begin : g_first
            assign left_lt  = 1'b1;
            assign left_tag = tag_vec[gi];
         end else begin : g_mid
            assign left_lt  = lt_vec[gi-1];
            assign left_tag = tag_vec[gi-1];
         end

         if (gi == TAG_SLOTS - 1) begin : g_last
            assign right_tag = tag_vec[gi];
         end else begin : g_inner
            assign right_tag = tag_vec[gi+1];
         end

         stf_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .occupied  (occ_vec[gi]),
            .left_lt   (left_lt),
            .left_tag  (left_tag),
            .right_tag (right_tag),
            .tag_out   (tag_vec[gi]),
            .lt_out    (lt_vec[gi]),
            .eq_out    (eq_vec[gi])
         );
      end
   endgenerate

   // decision for the apply cycle
   always_comb begin
      rsp_in   = '0;
      count_in = count_ff;
      apply_op = CELL_HOLD;
      unique case (req_ff.command)
         CMD_ADD: begin
            if (any_eq_ff) begin
               rsp_in.add_status = ADD_DUPLICATE;
            end else if (count_ff == CW'(TAG_SLOTS)) begin
               rsp_in.add_status = ADD_FULL;
            end else begin
               rsp_in.add_status = ADD_INSERTED;
               apply_op          = CELL_INSERT;
               count_in          = count_ff + CW'(1);
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         CMD_QUERY: begin
            if (count_ff == '0) begin
               rsp_in.stop_reading = 1'b1;
            end else if (req_ff.tag[31:16] != ITEM_GROUP && all_lt_ff) begin
               // tag lies above the largest wanted tag
               rsp_in.stop_reading = 1'b1;
            end else if (any_eq_ff) begin
               rsp_in.read_element = 1'b1;
               apply_op            = CELL_REMOVE;
               count_in            = count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cell_ctrl.tag = req_ff.tag;
      unique case (state_ff)
         ST_COMPARE: cell_ctrl.op = CELL_COMPARE;
         ST_APPLY:   cell_ctrl.op = apply_op;
         default:    cell_ctrl.op = CELL_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  state_ff <= ST_COMPARE;
               end
            end
            ST_COMPARE: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               any_eq_ff <= |eq_vec;
               all_lt_ff <= &(lt_vec | ~occ_vec);
               state_ff  <= ST_APPLY;
            end
            ST_APPLY: begin
               count_ff      <= count_in;
               rsp_ff        <= rsp_in;
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== src/stf_cell.sv =====
// One slot of the sorted tag row: holds a tag and its compare flags.
// Depends on stf_pkg.
module stf_cell (
   input  logic                         clock,
   input  stf_pkg::cell_ctrl_type       ctrl,
   input  logic                         occupied,
   input  logic                         left_lt,
   input  logic [stf_pkg::TAG_W-1:0]    left_tag,
   input  logic [stf_pkg::TAG_W-1:0]    right_tag,
   output logic [stf_pkg::TAG_W-1:0]    tag_out,
   output logic                         lt_out,
   output logic                         eq_out
);
   import stf_pkg::*;

   logic [TAG_W-1:0] tag_ff;
   logic             lt_ff;
   logic             eq_ff;

   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         CELL_COMPARE: begin
            lt_ff <= occupied && (tag_ff < ctrl.tag);
            eq_ff <= occupied && (tag_ff == ctrl.tag);
         end
         CELL_INSERT: begin
            // slots at or above the insert point move up one place
            if (!lt_ff) begin
               tag_ff <= left_lt ? ctrl.tag : left_tag;
            end
         end
         CELL_REMOVE: begin
            if (!lt_ff) begin
               tag_ff <= right_tag;
            end
         end
         CELL_HOLD: begin
         end
      endcase
   end

   assign tag_out = tag_ff;
   assign lt_out  = lt_ff;
   assign eq_out  = eq_ff;

endmodule

// ===== src/stf_checker.sv =====
// Port-level checks for the sorted tag filter, bound to the top level.
// Depends on stf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stf_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input stf_pkg::req_type req_data,
   input logic             rsp_strobe,
   input stf_pkg::rsp_type rsp_data
);
   import stf_pkg::*;

   `STF_ASSERT(a_latency, (start && !busy) |-> ##4 rsp_strobe, "result missing 4 cycles after accept")
   `STF_ASSERT(a_no_orphan, rsp_strobe |-> $past(start && !busy, 4), "result without a transaction")
   `STF_ASSERT(a_status_add, (rsp_strobe && rsp_data.add_status != ADD_INSERTED) |-> $past(req_data.command, 4) == CMD_ADD, "add status on non-add")
   `STF_ASSERT(a_read_stop, !(rsp_strobe && rsp_data.read_element && rsp_data.stop_reading), "read and stop together")
   `STF_ASSERT_ALWAYS(a_reset_idle, reset |=> (!busy && !rsp_strobe), "block not idle after reset")

endmodule

bind sorted_tag_filter_unit stf_checker u_stf_checker (.*);

// ===== dv/tb_sorted_tag_filter_unit.sv =====
// Self-checking testbench for sorted_tag_filter_unit: a directed pass, then random add,
// clear and query traffic, with every result checked against an in-bench tag-set model.
// Depends on stf_pkg and the block's RTL.
module tb_sorted_tag_filter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import stf_pkg::*;

   localparam int SLOTS = 16;
   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 500;
   localparam int POOL_SIZE = 24;
   localparam int MAX_PRINTED = 30;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Tag-set model plus the queue of results still owed by the block.
   class tag_filter_scoreboard;
      logic [TAG_W-1:0] wanted[SLOTS];
      int wanted_count;
      rsp_type owed[$];
      int errors, n_checked;
      int n_insert, n_dup, n_full, n_clear, n_read, n_stop, n_skip;

      function new();
         wanted_count = 0;
      endfunction

      // First slot whose tag is not below t.
      function int lower_slot(logic [TAG_W-1:0] t);
         int i;
         i = 0;
         while (i < wanted_count && wanted[i] < t) i++;
         return i;
      endfunction

      function rsp_type filter_outcome(req_type r);
         rsp_type res;
         int p;
         res = '0;
         case (r.command)
            CMD_ADD: begin
               p = lower_slot(r.tag);
               if (p < wanted_count && wanted[p] == r.tag) begin
                  res.add_status = ADD_DUPLICATE;
                  n_dup++;
               end else if (wanted_count >= SLOTS) begin
                  res.add_status = ADD_FULL;
                  n_full++;
               end else begin
                  for (int i = wanted_count; i > p; i--) wanted[i] = wanted[i-1];
                  wanted[p] = r.tag;
                  wanted_count++;
                  res.add_status = ADD_INSERTED;
                  n_insert++;
               end
            end
            CMD_CLEAR: begin
               wanted_count = 0;
               n_clear++;
            end
            CMD_QUERY: begin
               if (wanted_count == 0) begin
                  res.stop_reading = 1'b1;
                  n_stop++;
               end else if (r.tag[31:16] != ITEM_GROUP && r.tag > wanted[wanted_count-1]) begin
                  res.stop_reading = 1'b1;
                  n_stop++;
               end else begin
                  p = lower_slot(r.tag);
                  if (p < wanted_count && wanted[p] == r.tag) begin
                     for (int i = p; i + 1 < wanted_count; i++) wanted[i] = wanted[i+1];
                     wanted_count--;
                     res.read_element = 1'b1;
                     n_read++;
                  end else begin
                     n_skip++;
                  end
               end
            end
            default: ;
         endcase
         return res;
      endfunction

      function void note_request(req_type r);
         owed = {owed, filter_outcome(r)};
      endfunction

      task report(string msg);
         if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            report("result strobe with no transaction outstanding");
         end else begin
            want = owed.pop_front();
            n_checked++;
            if (got.read_element !== want.read_element)
               report($sformatf("read_element got %b want %b", got.read_element,
                                want.read_element));
            if (got.stop_reading !== want.stop_reading)
               report($sformatf("stop_reading got %b want %b", got.stop_reading,
                                want.stop_reading));
            if (got.add_status !== want.add_status)
               report($sformatf("add_status got %0d want %0d", got.add_status,
                                want.add_status));
         end
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   tag_filter_scoreboard sb;
   int idle_cycles;
   int burst_left;
   int n_sent;
   logic [TAG_W-1:0] tag_pool[POOL_SIZE];

   sorted_tag_filter_unit #(.TAG_SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Monitor and watchdog: outputs sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_data);
         if (rsp_strobe) sb.check_response(rsp_data);
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Sender runs in bursts; a gap drops start at falling edges before the next burst.
   task automatic send_cmd(input logic [1:0] cmd, input logic [TAG_W-1:0] tag);
      req_type r;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      r.command = cmd;
      r.tag = tag;
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      n_sent++;
   endtask

   function automatic logic [TAG_W-1:0] pick_tag();
      int mode;
      mode = $urandom_range(0, 99);
      if (mode < 70) return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (mode < 85) return {ITEM_GROUP, 16'($urandom)};
      return $urandom;
   endfunction

   initial begin
      int n_add, n_query, k;
      sb = new();
      idle_cycles = 0;
      burst_left = 0;
      n_sent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty set, duplicate, stop by magnitude, item group, unused code, full set.
      send_cmd(CMD_CLEAR, 32'h0);
      send_cmd(CMD_QUERY, 32'h0010_0010);
      send_cmd(CMD_ADD, 32'h0010_0010);
      send_cmd(CMD_ADD, 32'h0010_0010);
      send_cmd(CMD_QUERY, 32'h0020_0000);
      send_cmd(CMD_QUERY, 32'hFFFE_0000);
      send_cmd(CMD_ADD, 32'hFFFE_00DD);
      send_cmd(CMD_QUERY, 32'hFFFE_00DD);
      send_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
      send_cmd(CMD_ADD, 32'h0000_0000);
      send_cmd(CMD_ADD, 32'hFFFF_FFFF);
      for (int i = 0; i < SLOTS - 3; i++) send_cmd(CMD_ADD, 32'h4000_0000 + i * 32'h0101_0101);
      send_cmd(CMD_ADD, 32'h1234_5678);
      send_cmd(CMD_ADD, 32'h0000_0000);
      send_cmd(CMD_QUERY, 32'h0000_0000);
      send_cmd(CMD_QUERY, 32'hFFFF_FFFF);
      send_cmd(CMD_QUERY, 32'h4000_0080);
      send_cmd(CMD_CLEAR, 32'hFFFF_FFFF);

      // Small pool so adds collide, queries hit and the set fills up.
      tag_pool[0] = 32'h0000_0000;
      tag_pool[1] = 32'hFFFF_FFFF;
      tag_pool[2] = 32'hFFFE_0000;
      tag_pool[3] = 32'hFFFE_FFFF;
      tag_pool[4] = 32'h7FFF_FFFF;
      tag_pool[5] = 32'h8000_0000;
      for (int i = 6; i < POOL_SIZE; i++)
         tag_pool[i] = (i % 4 == 0) ? {ITEM_GROUP, 16'($urandom)} : $urandom;

      // Random phases: fill the set, then stream queries at it, with some noise mixed in.
      k = 0;
      while (k < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            send_cmd(CMD_CLEAR, $urandom);
            k++;
         end
         n_add = $urandom_range(1, 20);
         repeat (n_add) begin
            send_cmd(CMD_ADD, pick_tag());
            k++;
         end
         n_query = $urandom_range(1, 20);
         repeat (n_query) begin
            case ($urandom_range(0, 19))
               0:       send_cmd(CMD_UNUSED, $urandom);
               1:       send_cmd(CMD_ADD, pick_tag());
               default: send_cmd(CMD_QUERY, pick_tag());
            endcase
            k++;
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("ran %0d transactions, %0d results checked, %0d mismatches", n_sent,
               sb.n_checked, sb.errors);
      $display("adds %0d/%0d/%0d (ins/dup/full), clears %0d, queries %0d/%0d/%0d (read/stop/skip)",
               sb.n_insert, sb.n_dup, sb.n_full, sb.n_clear, sb.n_read, sb.n_stop, sb.n_skip);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
